// ----- hdl/tab_separated_decimal_line_parser_defines.svh -----
// Assertion macros for the line parser checker.
`ifndef TAB_SEPARATED_DECIMAL_LINE_PARSER_DEFINES_SVH
`define TAB_SEPARATED_DECIMAL_LINE_PARSER_DEFINES_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define TSDLP_CLK_ASSERT(name, ck, rstn, prop) \
  name: assert property (@(posedge ck) disable iff (!rstn) prop) \
    else $error("%m: assertion failed");

// Concurrent assertion on the block clock and reset.
`define TSDLP_ASSERT(name, prop) \
  `TSDLP_CLK_ASSERT(name, clk_i, rst_ni, prop)

`endif

// ----- hdl/tsdlp_pkg.sv -----
package tsdlp_pkg;

  // Default sizing
  localparam int unsigned LineBytesDef = 256;
  localparam int unsigned MaxDigitsDef = 9;

  // Field widths
  localparam int unsigned ByteW = 8;
  localparam int unsigned StatusW = 3;
  localparam int unsigned MantW = 31;
  localparam int unsigned DecW = 4;

  // Characters
  localparam logic [ByteW-1:0] ChLf = 8'h0A;
  localparam logic [ByteW-1:0] ChCr = 8'h0D;
  localparam logic [ByteW-1:0] ChTab = 8'h09;
  localparam logic [ByteW-1:0] ChDot = 8'h2E;
  localparam logic [ByteW-1:0] ChPlus = 8'h2B;
  localparam logic [ByteW-1:0] ChMinus = 8'h2D;
  localparam logic [ByteW-1:0] ChZero = 8'h30;
  localparam logic [ByteW-1:0] ChNine = 8'h39;

  // Line status codes
  localparam logic [StatusW-1:0] StOk = 3'd0;
  localparam logic [StatusW-1:0] StNoCr = 3'd1;
  localparam logic [StatusW-1:0] StShort = 3'd2;
  localparam logic [StatusW-1:0] StTabCount = 3'd3;
  localparam logic [StatusW-1:0] StTabPos = 3'd4;
  localparam logic [StatusW-1:0] StBadField = 3'd5;

  // Shortest line length not flagged as short, LF included
  localparam int unsigned MinLineBytes = 6;

  // Per-field parse flags
  typedef struct packed {
    logic pend_cr;
    logic error;
    logic started;
    logic dot;
    logic sign;
  } field_flags_t;

endpackage

// ----- hdl/tab_separated_decimal_line_parser.sv -----
// Channel | Direction | Handshake             | Payload
// input   | in        | in_valid_i/in_stall_o | rx_byte_i
// result  | out       | out_valid_o/out_stall_i | status_o, 3 x mantissa/decimals
//
// One byte per cycle sustained while no LF waits on a stalled result; an
// input byte is registered before parsing, and the LF result is registered.
// The parse state and the saved triple update in the single parse stage.
// Reset clears all line state and the saved triple to zero.
// A stalled result holds the parse stage only when it carries another LF;
// other bytes keep flowing past a waiting result.
module tab_separated_decimal_line_parser #(
  parameter int unsigned LINE_BYTES = tsdlp_pkg::LineBytesDef,
  parameter int unsigned MAX_DIGITS = tsdlp_pkg::MaxDigitsDef
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [tsdlp_pkg::ByteW-1:0]          rx_byte_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [tsdlp_pkg::StatusW-1:0]        status_o,
  output logic signed [tsdlp_pkg::MantW-1:0]   pressure_mantissa_o,
  output logic [tsdlp_pkg::DecW-1:0]           pressure_decimals_o,
  output logic signed [tsdlp_pkg::MantW-1:0]   temperature_mantissa_o,
  output logic [tsdlp_pkg::DecW-1:0]           temperature_decimals_o,
  output logic signed [tsdlp_pkg::MantW-1:0]   conductivity_mantissa_o,
  output logic [tsdlp_pkg::DecW-1:0]           conductivity_decimals_o
);

  localparam int unsigned CntW = $clog2(LINE_BYTES + 1);
  localparam int unsigned DigW = $clog2(MAX_DIGITS + 1);
  localparam int unsigned MantW = tsdlp_pkg::MantW;
  localparam int unsigned DecW = tsdlp_pkg::DecW;
  localparam int unsigned ByteW = tsdlp_pkg::ByteW;

  // Input register
  logic             s1_valid_q;
  logic [ByteW-1:0] s1_byte_q;
  logic             s1_is_lf;
  logic             out_free;
  logic             s1_go;
  logic             in_accept;

  // Line state
  logic [CntW-1:0]             cnt_q, cnt_d;
  logic [1:0]                  tab_q, tab_d;
  logic [MantW-1:0]            acc_q, acc_d;
  tsdlp_pkg::field_flags_t     ff_q, ff_d;
  logic [DigW-1:0]             dig_q, dig_d;
  logic [DigW-1:0]             frac_q, frac_d;
  logic                        le_bad_q, le_bad_d;
  logic                        le_first_q, le_first_d;

  // Pending first two fields, written on a TAB
  logic [MantW-1:0]            pend_mant_q [2];
  logic [DecW-1:0]             pend_dec_q [2];
  logic                        pend_we;
  logic                        pend_idx;

  // Saved triple, shown on the result ports
  logic [MantW-1:0]            save_mant_q [3];
  logic [DecW-1:0]             save_dec_q [3];
  logic                        save_we;

  logic [MantW-1:0]            fld_mant;
  logic [DecW-1:0]             fld_dec;
  logic [DigW+DecW-1:0]        frac_ext;
  logic [tsdlp_pkg::StatusW-1:0] status_d, status_q;
  logic                        out_valid_q;

  // Handshake
  assign s1_is_lf   = (s1_byte_q == tsdlp_pkg::ChLf);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_go      = s1_valid_q && (!s1_is_lf || out_free);
  assign in_stall_o = s1_valid_q && !s1_go;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_go) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_byte_q <= rx_byte_i;
    end
  end

  // Current field value, sign applied modulo 2^31
  assign fld_mant = ff_q.sign ? (MantW'(0) - acc_q) : acc_q;
  assign frac_ext = {{DecW{1'b0}}, frac_q};
  assign fld_dec  = frac_ext[DecW-1:0];

  // Parse one byte
  always_comb begin
    logic [ByteW-1:0] b;
    b          = s1_byte_q;
    cnt_d      = cnt_q;
    tab_d      = tab_q;
    acc_d      = acc_q;
    ff_d       = ff_q;
    dig_d      = dig_q;
    frac_d     = frac_q;
    le_bad_d   = le_bad_q;
    le_first_d = le_first_q;
    pend_we    = 1'b0;
    pend_idx   = tab_q[0];
    save_we    = 1'b0;
    status_d   = tsdlp_pkg::StOk;

    // Long line: drop everything and start over with this byte
    if (cnt_q >= CntW'(LINE_BYTES)) begin
      cnt_d      = '0;
      tab_d      = '0;
      acc_d      = '0;
      ff_d       = '0;
      dig_d      = '0;
      frac_d     = '0;
      le_bad_d   = 1'b0;
      le_first_d = 1'b0;
    end
    cnt_d = cnt_d + CntW'(1);

    if (b == tsdlp_pkg::ChLf) begin
      // End of line: checks in priority order
      if (cnt_d == CntW'(1) || !ff_d.pend_cr) begin
        status_d = tsdlp_pkg::StNoCr;
      end else if (cnt_d < CntW'(tsdlp_pkg::MinLineBytes)) begin
        status_d = tsdlp_pkg::StShort;
      end else if (tab_d != 2'd2) begin
        status_d = tsdlp_pkg::StTabCount;
      end else if (le_first_d || !ff_d.started) begin
        status_d = tsdlp_pkg::StTabPos;
      end else if (le_bad_d || ff_d.error) begin
        status_d = tsdlp_pkg::StBadField;
      end else begin
        status_d = tsdlp_pkg::StOk;
      end
      save_we    = (status_d == tsdlp_pkg::StOk);
      cnt_d      = '0;
      tab_d      = '0;
      acc_d      = '0;
      ff_d       = '0;
      dig_d      = '0;
      frac_d     = '0;
      le_bad_d   = 1'b0;
      le_first_d = 1'b0;
    end else begin
      // CR not followed by LF is a bad character
      if (ff_d.pend_cr) begin
        ff_d.pend_cr = 1'b0;
        if (tab_d != 2'd3) begin
          ff_d.error   = 1'b1;
          ff_d.started = 1'b1;
        end
      end

      if (b == tsdlp_pkg::ChCr) begin
        ff_d.pend_cr = 1'b1;
      end else if (b == tsdlp_pkg::ChTab) begin
        if (tab_d < 2'd2) begin
          if (!ff_d.started) begin
            if (tab_d == 2'd0) begin
              le_first_d = 1'b1;
            end else begin
              le_bad_d = 1'b1;
            end
          end
          if (ff_d.error) begin
            le_bad_d = 1'b1;
          end
          pend_we     = 1'b1;
          acc_d       = '0;
          ff_d        = '0;
          dig_d       = '0;
          frac_d      = '0;
          tab_d       = tab_d + 2'd1;
        end else begin
          tab_d = 2'd3;
        end
      end else if (tab_d != 2'd3) begin
        // Field character
        if (b == tsdlp_pkg::ChDot) begin
          ff_d.dot = 1'b1;
        end else if (b >= tsdlp_pkg::ChZero && b <= tsdlp_pkg::ChNine) begin
          if (dig_d >= DigW'(MAX_DIGITS)) begin
            ff_d.error = 1'b1;
          end else begin
            acc_d = (acc_d << 3) + (acc_d << 1) + MantW'(b[3:0]);
            dig_d = dig_d + DigW'(1);
            if (ff_d.dot) begin
              frac_d = frac_d + DigW'(1);
            end
          end
        end else if (!ff_d.started &&
                     (b == tsdlp_pkg::ChMinus || b == tsdlp_pkg::ChPlus)) begin
          if (b == tsdlp_pkg::ChMinus) begin
            ff_d.sign = 1'b1;
          end
        end else begin
          ff_d.error = 1'b1;
        end
        ff_d.started = 1'b1;
      end
    end
  end

  // Line state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q      <= '0;
      tab_q      <= '0;
      acc_q      <= '0;
      ff_q       <= '0;
      dig_q      <= '0;
      frac_q     <= '0;
      le_bad_q   <= 1'b0;
      le_first_q <= 1'b0;
    end else if (s1_go) begin
      cnt_q      <= cnt_d;
      tab_q      <= tab_d;
      acc_q      <= acc_d;
      ff_q       <= ff_d;
      dig_q      <= dig_d;
      frac_q     <= frac_d;
      le_bad_q   <= le_bad_d;
      le_first_q <= le_first_d;
    end
  end

  // Pending fields, no reset
  always_ff @(posedge clk_i) begin
    if (s1_go && pend_we) begin
      pend_mant_q[pend_idx] <= fld_mant;
      pend_dec_q[pend_idx]  <= fld_dec;
    end
  end

  // Saved triple, replaced on a good line
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        save_mant_q[i] <= '0;
        save_dec_q[i]  <= '0;
      end
    end else if (s1_go && save_we) begin
      save_mant_q[0] <= pend_mant_q[0];
      save_dec_q[0]  <= pend_dec_q[0];
      save_mant_q[1] <= pend_mant_q[1];
      save_dec_q[1]  <= pend_dec_q[1];
      save_mant_q[2] <= fld_mant;
      save_dec_q[2]  <= fld_dec;
    end
  end

  // Result register; the triple only changes when a new result is loaded
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s1_go && s1_is_lf;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_go && s1_is_lf) begin
      status_q <= status_d;
    end
  end

  assign out_valid_o             = out_valid_q;
  assign status_o                = status_q;
  assign pressure_mantissa_o     = save_mant_q[0];
  assign pressure_decimals_o     = save_dec_q[0];
  assign temperature_mantissa_o  = save_mant_q[1];
  assign temperature_decimals_o  = save_dec_q[1];
  assign conductivity_mantissa_o = save_mant_q[2];
  assign conductivity_decimals_o = save_dec_q[2];

endmodule

// ----- hdl/tsdlp_checker.sv -----
`include "tab_separated_decimal_line_parser_defines.svh"

module tsdlp_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_valid_i,
  input logic                                in_stall_o,
  input logic [tsdlp_pkg::ByteW-1:0]         rx_byte_i,
  input logic                                out_valid_o,
  input logic                                out_stall_i,
  input logic [tsdlp_pkg::StatusW-1:0]       status_o,
  input logic signed [tsdlp_pkg::MantW-1:0]  pressure_mantissa_o,
  input logic [tsdlp_pkg::DecW-1:0]          pressure_decimals_o,
  input logic signed [tsdlp_pkg::MantW-1:0]  temperature_mantissa_o,
  input logic [tsdlp_pkg::DecW-1:0]          temperature_decimals_o,
  input logic signed [tsdlp_pkg::MantW-1:0]  conductivity_mantissa_o,
  input logic [tsdlp_pkg::DecW-1:0]          conductivity_decimals_o
);

  logic                                              lf_taken;
  logic [2*(tsdlp_pkg::MantW+tsdlp_pkg::DecW)-1:0]   front_pair;
  logic [tsdlp_pkg::MantW+tsdlp_pkg::DecW-1:0]       cond_field;

  // LF item taken at the input
  assign lf_taken = in_valid_i && !in_stall_o && (rx_byte_i == tsdlp_pkg::ChLf);

  // Saved values on the result ports
  assign front_pair = {pressure_mantissa_o, pressure_decimals_o,
                       temperature_mantissa_o, temperature_decimals_o};
  assign cond_field = {conductivity_mantissa_o, conductivity_decimals_o};

  // A stalled result item stays offered
  `TSDLP_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o)

  // A fresh result follows an accepted LF through the input and result registers
  `TSDLP_ASSERT(a_result_after_lf, $rose(out_valid_o) |-> $past(lf_taken, 2))

  // The saved triple moves only with a good-line result
  `TSDLP_ASSERT(a_front_on_ok, !$stable(front_pair) |-> out_valid_o && status_o == tsdlp_pkg::StOk)
  `TSDLP_ASSERT(a_cond_on_ok, !$stable(cond_field) |-> out_valid_o && status_o == tsdlp_pkg::StOk)

endmodule

bind tab_separated_decimal_line_parser tsdlp_checker u_tsdlp_checker (.*);
